[rtl/ccfp_pkg.sv]
// Shared constants, phase encoding and result type for the camera corner frame parser.
// Used by every module of the block; depends on nothing.
package ccfp_pkg;

    localparam int FRAME_LEN   = 22;
    localparam int NUM_COORDS  = 10;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 5;
    localparam int LIMIT_W     = 5;
    localparam int STORE_IDX_W = 4;
    localparam int DATA_W      = NUM_COORDS * BYTE_W;

    localparam logic [BYTE_W-1:0]  HDR_FIRST   = 8'h2C;
    localparam logic [BYTE_W-1:0]  HDR_SECOND  = 8'h12;
    localparam logic [BYTE_W-1:0]  TAIL_BYTE   = 8'h5B;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd20;

    // First and last frame positions that carry a coordinate (even positions only)
    localparam logic [COUNT_W-1:0] COORD_FIRST_POS = 5'd2;
    localparam logic [COUNT_W-1:0] COORD_LAST_POS  = 5'd20;

    typedef enum logic [1:0] {
        PH_HUNT_FIRST  = 2'd0,
        PH_HUNT_SECOND = 2'd1,
        PH_COLLECT     = 2'd2,
        PH_DONE        = 2'd3
    } phase_t;

    typedef logic [NUM_COORDS-1:0][BYTE_W-1:0] coords_t;

    typedef struct packed {
        coords_t coords;
        logic    updated;
    } result_t;

endpackage

[rtl/camera_corner_frame_parser_unit.sv]
// Camera corner frame parser. Takes one link byte per request and delivers the
// corner and target coordinates of each full frame.
// Slave channel s_*: one received byte per request in s_tdata.
// Master channel m_*: one request per full 22-byte frame; m_tdata holds ten
//   coordinates, m_tuser says whether this frame refreshed them.
// Configuration: cfg_wr_en/cfg_wr_data write the update limit (reset 20);
//   coordinates are refreshed only while fewer frames than the limit were taken.
// Path: the final frame byte passes the input register, then the result
//   register, before its result appears on m_*.
// Throughput: one byte per cycle unless a sink stall holds the result register;
//   parse state and coordinates update per consumed byte, so bytes run back to back.
// Reset (aresetn low, synchronous): parser hunts for the header, coordinates
//   and taken-frame count are zero, limit is 20, both channels are empty.
// Sink stall: the result register holds; the held byte waits in the input
//   register, and s_tready drops only when both registers are occupied.
module camera_corner_frame_parser_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ccfp_pkg::LIMIT_W-1:0]  cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: [7:0] rx_byte
    input  logic [ccfp_pkg::BYTE_W-1:0]   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: [7:0] left_bottom_x, [15:8] left_bottom_y, [23:16] right_bottom_x,
    // [31:24] right_bottom_y, [39:32] right_top_x, [47:40] right_top_y,
    // [55:48] left_top_x, [63:56] left_top_y, [71:64] target_x, [79:72] target_y
    output logic [ccfp_pkg::DATA_W-1:0]   m_tdata,
    // m_tuser: [0] updated
    output logic                          m_tuser
);

    logic                        item_valid;
    logic [ccfp_pkg::BYTE_W-1:0] item_byte;
    logic                        item_fire;
    logic                        out_free;
    logic                        res_valid;
    ccfp_pkg::result_t           res;

    // Consume the held byte whenever the result register can take its outcome
    assign item_fire = item_valid && out_free;

    ccfp_in_reg u_in_reg (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .consume    (item_fire),
        .item_valid (item_valid),
        .item_byte  (item_byte)
    );

    ccfp_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_fire   (item_fire),
        .item_byte   (item_byte),
        .res_valid   (res_valid),
        .res         (res)
    );

    ccfp_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (item_fire),
        .res_valid (res_valid),
        .res       (res),
        .out_free  (out_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule

[rtl/ccfp_in_reg.sv]
// Input register of the parser: holds one received byte until the core consumes it.
// Depends on ccfp_pkg for the byte width.
module ccfp_in_reg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ccfp_pkg::BYTE_W-1:0]  s_tdata,
    input  logic                         consume,
    output logic                         item_valid,
    output logic [ccfp_pkg::BYTE_W-1:0]  item_byte
);

    logic                        valid_reg;
    logic                        valid_next;
    logic [ccfp_pkg::BYTE_W-1:0] byte_reg;

    // Accept when empty or when the held byte leaves this cycle
    assign s_tready = !valid_reg || consume;

    always_comb begin
        valid_next = valid_reg;
        if (s_tvalid && s_tready) begin
            valid_next = 1'b1;
        end else if (consume) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Capture the payload on each accepted request
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            byte_reg <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item_byte  = byte_reg;

endmodule

[rtl/ccfp_core.sv]
// Frame parser core: header hunt, frame byte count, coordinate byte store, corner
// assignment and the update limit register. Depends on ccfp_pkg.
module ccfp_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [ccfp_pkg::LIMIT_W-1:0]  cfg_wr_data,
    input  logic                          item_fire,
    input  logic [ccfp_pkg::BYTE_W-1:0]   item_byte,
    output logic                          res_valid,
    output ccfp_pkg::result_t             res
);

    ccfp_pkg::phase_t                     phase_reg;
    ccfp_pkg::phase_t                     phase_next;
    logic [ccfp_pkg::COUNT_W-1:0]         count_reg;
    logic [ccfp_pkg::COUNT_W-1:0]         count_next;
    logic [ccfp_pkg::COUNT_W-1:0]         count_inc;
    logic [ccfp_pkg::LIMIT_W-1:0]         limit_reg;
    logic [ccfp_pkg::LIMIT_W-1:0]         taken_reg;
    ccfp_pkg::coords_t                    coord_reg;
    ccfp_pkg::coords_t                    coord_new;
    logic [ccfp_pkg::BYTE_W-1:0]          even_store [ccfp_pkg::NUM_COORDS];
    logic [ccfp_pkg::STORE_IDX_W-1:0]     store_idx;
    logic                                 store_wr;
    logic                                 collect;
    logic                                 is_tail;
    logic                                 full;
    logic                                 take;

    assign count_inc = count_reg + 5'd1;
    assign collect   = (phase_reg == ccfp_pkg::PH_COLLECT);
    assign is_tail   = (item_byte == ccfp_pkg::TAIL_BYTE);
    assign full      = collect && (count_inc == ccfp_pkg::COUNT_W'(ccfp_pkg::FRAME_LEN));
    assign take      = full && (taken_reg < limit_reg);

    // Next phase and byte count
    always_comb begin
        phase_next = phase_reg;
        count_next = count_reg;
        case (phase_reg)
            ccfp_pkg::PH_HUNT_FIRST: begin
                if (item_byte == ccfp_pkg::HDR_FIRST) begin
                    phase_next = ccfp_pkg::PH_HUNT_SECOND;
                    count_next = count_inc;
                end else begin
                    phase_next = ccfp_pkg::PH_HUNT_FIRST;
                    count_next = '0;
                end
            end
            ccfp_pkg::PH_HUNT_SECOND: begin
                if (item_byte == ccfp_pkg::HDR_SECOND) begin
                    phase_next = ccfp_pkg::PH_COLLECT;
                    count_next = count_inc;
                end else begin
                    phase_next = ccfp_pkg::PH_HUNT_FIRST;
                    count_next = '0;
                end
            end
            ccfp_pkg::PH_COLLECT: begin
                count_next = count_inc;
                if (full || is_tail) begin
                    phase_next = ccfp_pkg::PH_DONE;
                end
            end
            ccfp_pkg::PH_DONE: begin
                phase_next = ccfp_pkg::PH_HUNT_FIRST;
                count_next = '0;
            end
            default: begin
                phase_next = ccfp_pkg::PH_HUNT_FIRST;
                count_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= ccfp_pkg::PH_HUNT_FIRST;
            count_reg <= '0;
        end else if (item_fire) begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

    // Keep only the even positions 2..20 that carry coordinates
    assign store_idx = count_reg[ccfp_pkg::COUNT_W-1:1] - 4'd1;
    assign store_wr  = item_fire && collect && !count_reg[0]
                       && (count_reg >= ccfp_pkg::COORD_FIRST_POS)
                       && (count_reg <= ccfp_pkg::COORD_LAST_POS);

    always_ff @(posedge aclk) begin
        if (store_wr) begin
            even_store[store_idx] <= item_byte;
        end
    end

    // Corner assignment, rotated when byte 4 exceeds byte 8
    always_comb begin
        if (even_store[1] > even_store[3]) begin
            coord_new[2] = even_store[0];
            coord_new[3] = even_store[1];
            coord_new[4] = even_store[2];
            coord_new[5] = even_store[3];
            coord_new[6] = even_store[4];
            coord_new[7] = even_store[5];
            coord_new[0] = even_store[6];
            coord_new[1] = even_store[7];
        end else begin
            coord_new[0] = even_store[0];
            coord_new[1] = even_store[1];
            coord_new[2] = even_store[2];
            coord_new[3] = even_store[3];
            coord_new[4] = even_store[4];
            coord_new[5] = even_store[5];
            coord_new[6] = even_store[6];
            coord_new[7] = even_store[7];
        end
        coord_new[8] = even_store[8];
        coord_new[9] = even_store[9];
    end

    // Hold coordinates and the taken-frame count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coord_reg <= '0;
            taken_reg <= '0;
        end else if (item_fire && take) begin
            coord_reg <= coord_new;
            taken_reg <= taken_reg + 5'd1;
        end
    end

    // Update limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= ccfp_pkg::LIMIT_RESET;
        end else if (cfg_wr_en) begin
            limit_reg <= cfg_wr_data;
        end
    end

    // Result of the byte in the input register
    always_comb begin
        res_valid   = item_fire && full;
        res.coords  = take ? coord_new : coord_reg;
        res.updated = take;
    end

endmodule

[rtl/ccfp_out_reg.sv]
// Result register of the parser: holds one coordinate request until the sink takes it.
// Depends on ccfp_pkg for the result type.
module ccfp_out_reg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic                          res_valid,
    input  ccfp_pkg::result_t             res,
    output logic                          out_free,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [ccfp_pkg::DATA_W-1:0]   m_tdata,
    output logic                          m_tuser
);

    logic              valid_reg;
    logic              valid_next;
    ccfp_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    // Load on a consumed byte, drop once the sink takes the request
    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = res_valid;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = res_reg.coords;
    assign m_tuser  = res_reg.updated;

endmodule

[rtl/ccfp_checker.sv]
// Port-level checks for the camera corner frame parser, bound to the top level.
// Depends on ccfp_pkg for widths.
module ccfp_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [ccfp_pkg::DATA_W-1:0]   m_tdata,
    input  logic                          m_tuser
);

    // Results are empty right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds its payload
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A new result needs a source byte accepted ahead of the input and result registers
    a_rise_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a source byte");

    // A held (not refreshed) result repeats the coordinates just delivered
    a_held_repeat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser && $past(m_tvalid && m_tready) && $past(aresetn)
        |-> m_tdata == $past(m_tdata))
        else $error("held coordinates changed");

endmodule

bind camera_corner_frame_parser_unit ccfp_checker u_ccfp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
